// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define ACP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ACP_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/acp_pkg.sv =====
// types, constants and helpers for the ascii can command parser
package acp_pkg;

  localparam int MAX_DATA_BYTES_DEF = 8;

  localparam logic [7:0] CH_OPEN  = 8'h4F;  // 'O'
  localparam logic [7:0] CH_CLOSE = 8'h43;  // 'C'
  localparam logic [7:0] CH_STD   = 8'h74;  // 't'
  localparam logic [7:0] CH_EXT   = 8'h54;  // 'T'

  localparam logic [4:0] ID_DIGITS_STD = 5'd3;
  localparam logic [4:0] ID_DIGITS_EXT = 5'd8;
  localparam logic [4:0] POS_MAX       = 5'd31;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_STD   = 3'd3,
    KIND_EXT   = 3'd4,
    KIND_ERR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_SEND  = 2'd2,
    ACT_BELL  = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] frame_id;
    logic        extended;
    logic [3:0]  data_len;
    logic [63:0] payload;
  } result_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61) begin
      v = c - 8'h57;
    end else if (c >= 8'h41) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h30;
    end
    hex_digit = v[3:0];
  endfunction

endpackage

// ===== rtl/acp_parse.sv =====
// command parsing state and per-character update
`include "assert_macros.svh"

module acp_parse #(
  parameter int MAX_DATA_BYTES = acp_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       char_in,
  input  logic             last_char,
  output acp_pkg::result_t res
);

  localparam int DW = MAX_DATA_BYTES * 8;
  localparam logic [3:0] LEN_MAX = 4'(MAX_DATA_BYTES);

  logic [4:0]          pos_r, pos_nxt;
  acp_pkg::kind_t      kind_r, kind_nxt;
  logic [31:0]         id_r, id_nxt;
  logic [3:0]          len_r, len_nxt;
  logic [DW-1:0]       data_r, data_nxt;
  logic                stop_r, stop_nxt;

  logic       frame;
  logic [4:0] idlen;
  logic [4:0] lenpos;
  logic [4:0] rel;
  logic [3:0] bidx;
  logic       in_id;
  logic       in_len;
  logic       first;
  logic       take;
  logic       hex_ok;
  logic [3:0] dig;

  always_comb begin
    frame  = (pos_r != 5'd0) &&
             (kind_r == acp_pkg::KIND_STD || kind_r == acp_pkg::KIND_EXT);
    idlen  = (kind_r == acp_pkg::KIND_EXT) ? acp_pkg::ID_DIGITS_EXT : acp_pkg::ID_DIGITS_STD;
    lenpos = idlen + 5'd1;
    rel    = pos_r - lenpos - 5'd1;
    bidx   = rel[4:1];
    in_id  = pos_r <= idlen;
    in_len = pos_r == lenpos;
    // each field (identifier, length, every data byte) restarts its stop flag
    first  = in_id ? (pos_r == 5'd1) : (in_len ? 1'b1 : !rel[0]);
    take   = frame && (in_id || in_len ||
             (bidx < len_r && {1'b0, bidx} < 5'(MAX_DATA_BYTES)));
    hex_ok = acp_pkg::is_hex(char_in);
    dig    = acp_pkg::hex_digit(char_in);

    kind_nxt = kind_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    data_nxt = data_r;
    stop_nxt = stop_r;

    if (pos_r == 5'd0) begin
      unique case (char_in)
        acp_pkg::CH_OPEN:  kind_nxt = acp_pkg::KIND_OPEN;
        acp_pkg::CH_CLOSE: kind_nxt = acp_pkg::KIND_CLOSE;
        acp_pkg::CH_STD:   kind_nxt = acp_pkg::KIND_STD;
        acp_pkg::CH_EXT:   kind_nxt = acp_pkg::KIND_EXT;
        default:           kind_nxt = acp_pkg::KIND_ERR;
      endcase
    end

    if (take) begin
      stop_nxt = first ? 1'b0 : stop_r;
      if (first || !stop_r) begin
        if (!hex_ok) begin
          stop_nxt = 1'b1;
        end else if (in_id) begin
          id_nxt = {id_r[27:0], dig};
        end else if (in_len) begin
          len_nxt = (dig > LEN_MAX) ? LEN_MAX : dig;
        end else begin
          for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            if (bidx == 4'(i)) begin
              data_nxt[i*8 +: 8] = first ? {4'b0000, dig} : {data_r[i*8 +: 4], dig};
            end
          end
        end
      end
    end

    pos_nxt = (pos_r == acp_pkg::POS_MAX) ? pos_r : pos_r + 5'd1;

    res = '0;
    unique case (kind_nxt)
      acp_pkg::KIND_OPEN:  res.action = acp_pkg::ACT_OPEN;
      acp_pkg::KIND_CLOSE: res.action = acp_pkg::ACT_CLOSE;
      acp_pkg::KIND_STD, acp_pkg::KIND_EXT: begin
        res.action   = acp_pkg::ACT_SEND;
        res.frame_id = id_nxt;
        res.extended = (kind_nxt == acp_pkg::KIND_EXT);
        res.data_len = len_nxt;
        res.payload  = 64'(data_nxt);
      end
      default:             res.action = acp_pkg::ACT_BELL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= acp_pkg::KIND_NONE;
      id_r   <= '0;
      len_r  <= '0;
      data_r <= '0;
      stop_r <= 1'b0;
    end else if (step) begin
      if (last_char) begin
        pos_r  <= '0;
        kind_r <= acp_pkg::KIND_NONE;
        id_r   <= '0;
        len_r  <= '0;
        data_r <= '0;
        stop_r <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        kind_r <= kind_nxt;
        id_r   <= id_nxt;
        len_r  <= len_nxt;
        data_r <= data_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

  `ACP_ASSERT_RST(a_clear_after_last, clk, rst_n, step && last_char |=> pos_r == 5'd0 && kind_r == acp_pkg::KIND_NONE, "state not cleared after last item")
  `ACP_ASSERT_RST(a_len_limit, clk, rst_n, len_r <= LEN_MAX, "length beyond limit")
  `ACP_ASSERT_RST(a_kind_set, clk, rst_n, pos_r != 5'd0 |-> kind_r != acp_pkg::KIND_NONE, "command kind missing mid command")

endmodule

// ===== rtl/ascii_can_command_parser.sv =====
// ascii can command parser: one character per item, one result per command.
// Each accepted character is held in an input register, then a
// single pass of short logic updates the parse state; on a command's last
// character the result is loaded into an output register. One item is taken
// every cycle; the input stage stalls only when a last character meets an
// output register still holding an untaken result. 'O' gives open, 'C' close,
// 't'/'T' a send-frame result with a hex identifier (3 or 8 digits), a length
// digit saturated at MAX_DATA_BYTES and two hex digits per data byte; anything
// else gives the bell result. The result is presented from the output register
// once the last character leaves the input register and the output one is free.
`include "assert_macros.svh"

module ascii_can_command_parser #(
  parameter int MAX_DATA_BYTES = acp_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_in
  input  logic         in_tlast,   // last_char
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [31:0] frame_id, [35:32] data_len, [99:36] payload, zero pad
  output logic [2:0]   out_tuser   // [1:0] action, [2] extended
);

  logic             in_valid_r;
  logic [7:0]       in_char_r;
  logic             in_last_r;
  logic             out_valid_r;
  acp_pkg::result_t out_res_r;
  acp_pkg::result_t res;
  logic             out_free;
  logic             adv;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  acp_parse #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .char_in   (in_char_r),
    .last_char (in_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.payload, out_res_r.data_len, out_res_r.frame_id};
  assign out_tuser  = {out_res_r.extended, out_res_r.action};

  `ACP_ASSERT_RST(a_no_overwrite, clk, rst_n, out_valid_r && !out_tready |-> !(adv && in_last_r), "pending result overwritten")
  `ACP_ASSERT_RST(a_result_follows, clk, rst_n, adv && in_last_r |=> out_valid_r, "result not presented after last item")
  `ACP_ASSERT_CLK(a_reset_idle, clk, !rst_n |=> !out_valid_r && !in_valid_r, "stages not idle after reset")

endmodule
